// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/bfk_pkg.sv -----
// ----------------------------------------------------------------------------
// bfk_pkg
// Shared types and codes of the brute-force k-nearest-neighbor search.
// ----------------------------------------------------------------------------
package bfk_pkg;

   // result status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_BAD_POINT = 3'd1;
   localparam logic [2:0] ST_STORE_FULL = 3'd2;
   localparam logic [2:0] ST_NEIGHBOR = 3'd3;
   localparam logic [2:0] ST_QUERY_DONE = 3'd4;
   localparam logic [2:0] ST_QUERY_REJECT = 3'd5;

   // configuration register indexes
   localparam logic [1:0] CSR_DIMENSION = 2'd0;
   localparam logic [1:0] CSR_RADIUS = 2'd1;
   localparam logic [1:0] CSR_K = 2'd2;

   localparam logic [4:0] DIMENSION_RESET = 5'd16;
   localparam logic [15:0] RADIUS_RESET = 16'hFFFF;
   localparam logic [4:0] K_RESET = 5'd1;

   typedef struct packed {
      logic take;
      logic scan_start;
      logic scan_issue;
      logic emit_init;
      logic emit_step;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic query_go;
      logic issue_done;
      logic pipe_busy;
      logic emit_end;
   } stat_type;

endpackage

// ----- rtl/bfk_if.sv -----
// ----------------------------------------------------------------------------
// bfk interfaces
// Valid/ready channels of the search block: request, response, register write.
// ----------------------------------------------------------------------------
interface bfk_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] coordinate;
   logic [15:0] entry_key;
   logic        last_coordinate;

   modport source (output valid, kind, coordinate, entry_key, last_coordinate,
                   input ready);
   modport sink (input valid, kind, coordinate, entry_key, last_coordinate,
                 output ready);
endinterface

interface bfk_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] neighbor_key;
   logic        last_result;

   modport source (output valid, status, neighbor_key, last_result, input ready);
   modport sink (input valid, status, neighbor_key, last_result, output ready);
endinterface

interface bfk_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/brute_force_knn_search_top.sv -----
// An insert or a rejected query answers in the cycle after its closing item.
// A good query scans the store one stored coordinate per cycle through the
// single read port of the point RAM, covering every stored point in the query
// dimension, drains the distance pipeline, then steps through the kept
// candidates one per cycle while the response side accepts (those outside the
// radius are skipped but still take their step) and ends with the closing item.
// No clearing pass after reset.
// ----------------------------------------------------------------------------
// brute_force_knn_search_top
// Keyed point store with brute-force k-nearest-neighbor query.
// ----------------------------------------------------------------------------
module brute_force_knn_search_top #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIM = 16,
   parameter int MAX_K = 16,
   parameter int COORD_BITS = 16
) (
   input  logic   clock,
   input  logic   reset,
   bfk_req_if.sink   req_ch,
   bfk_rsp_if.source rsp_ch,
   bfk_csr_if.sink   csr_ch
);
   bfk_pkg::cmd_type  cmd;
   bfk_pkg::stat_type stat;
   logic              req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   bfk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bfk_dp #(
      .MAX_POINTS (MAX_POINTS),
      .MAX_DIM    (MAX_DIM),
      .MAX_K      (MAX_K),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_ch.kind),
      .req_coordinate      (req_ch.coordinate),
      .req_entry_key       (req_ch.entry_key),
      .req_last_coordinate (req_ch.last_coordinate),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_status          (rsp_ch.status),
      .rsp_neighbor_key    (rsp_ch.neighbor_key),
      .rsp_last_result     (rsp_ch.last_result),
      .csr_take            (csr_ch.valid),
      .csr_index           (csr_ch.index),
      .csr_data            (csr_ch.data)
   );
endmodule

// ----- rtl/bfk_ram.sv -----
// ----------------------------------------------------------------------------
// bfk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [ADDR_W-1:0]      waddr,
   input  logic [WIDTH-1:0]       wdata,
   input  logic [ADDR_W-1:0]      raddr,
   output logic [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ----- rtl/bfk_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfk_ctrl
// Sequencer: item intake, store scan, pipeline drain and result emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfk_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bfk_pkg::stat_type  stat,
   output bfk_pkg::cmd_type   cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      req_ready = (state_ff == S_IDLE) && stat.rsp_free;
      cmd.take = req_valid && req_ready;
      cmd.scan_start = cmd.take && stat.query_go;
      cmd.scan_issue = (state_ff == S_SCAN) && !stat.issue_done;
      cmd.emit_init = (state_ff == S_DRAIN) && !stat.pipe_busy;
      cmd.emit_step = (state_ff == S_EMIT) && stat.rsp_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (cmd.scan_start) state_in = S_SCAN;
         S_SCAN: if (stat.issue_done) state_in = S_DRAIN;
         S_DRAIN: if (!stat.pipe_busy) state_in = S_EMIT;
         S_EMIT: if (cmd.emit_step && stat.emit_end) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_CLK(a_pipe_only_in_scan, stat.pipe_busy |-> (state_ff == S_SCAN || state_ff == S_DRAIN), "distance pipeline busy outside a scan")
   `ASSERT_ALWAYS(a_take_only_idle, cmd.take |-> (state_ff == S_IDLE), "item taken while a query runs")
   `ASSERT_CLK(a_drain_to_emit, (state_ff == S_DRAIN && !stat.pipe_busy) |=> (state_ff == S_EMIT), "drained scan did not start emission")
endmodule

// ----- rtl/bfk_dp.sv -----
// ----------------------------------------------------------------------------
// bfk_dp
// Datapath: point and key stores, distance pipeline, sorted best list, output.
// ----------------------------------------------------------------------------
module bfk_dp #(
   parameter int MAX_POINTS = 1024,
   parameter int MAX_DIM = 16,
   parameter int MAX_K = 16,
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  bfk_pkg::cmd_type   cmd,
   output bfk_pkg::stat_type  stat,
   input  logic               req_kind,
   input  logic [15:0]        req_coordinate,
   input  logic [15:0]        req_entry_key,
   input  logic               req_last_coordinate,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_neighbor_key,
   output logic               rsp_last_result,
   input  logic               csr_take,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CI_W = $clog2(MAX_DIM + 1);
   localparam int DIX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int KC_W = $clog2(MAX_K + 1);
   localparam int KIX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int PDEPTH = MAX_POINTS * MAX_DIM;
   localparam int PA_W = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
   localparam int SQ_W = 2 * COORD_BITS;
   localparam int DIST_W = SQ_W + CI_W;
   localparam int CMP_W = (DIST_W > 32) ? DIST_W : 32;
   localparam int EQ_W = (CI_W > 5) ? CI_W : 5;
   localparam int KL_W = (KC_W > 5) ? KC_W + 1 : 6;

   // configuration
   logic [4:0]  dim_ff;
   logic [15:0] radius_ff;
   logic [4:0]  k_ff;
   logic [31:0] r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= bfk_pkg::DIMENSION_RESET;
         radius_ff <= bfk_pkg::RADIUS_RESET;
         k_ff <= bfk_pkg::K_RESET;
      end else if (csr_take) begin
         unique case (csr_index)
            bfk_pkg::CSR_DIMENSION: dim_ff <= csr_data[4:0];
            bfk_pkg::CSR_RADIUS: radius_ff <= csr_data;
            bfk_pkg::CSR_K: k_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= 32'(radius_ff) * 32'(radius_ff);
   end

   // point intake
   logic [CI_W-1:0]       ci_ff, count_now;
   logic                  inv_ff, inv_now, in_range, good, room;
   logic [CNT_W-1:0]      stored_ff;
   logic [31:0]           coord_x;
   logic [COORD_BITS-1:0] coord_v;
   logic [COORD_BITS-1:0] qbuf_ff [MAX_DIM];
   logic                  close_take, key_we, pt_we;
   logic [PA_W-1:0]       pt_waddr, pt_raddr;

   always_comb begin
      coord_x = 32'(req_coordinate);
      coord_v = coord_x[COORD_BITS-1:0];
      in_range = ci_ff < CI_W'(MAX_DIM);
      count_now = in_range ? ci_ff + CI_W'(1) : ci_ff;
      inv_now = inv_ff || !in_range || coord_v[COORD_BITS-1];
      good = !inv_now && (EQ_W'(count_now) == EQ_W'(dim_ff));
      room = stored_ff < CNT_W'(MAX_POINTS);
      close_take = cmd.take && req_last_coordinate;
      pt_we = cmd.take && in_range && room;
      key_we = close_take && !req_kind && good && room;
      pt_waddr = PA_W'(stored_ff[SLOT_W-1:0]) * PA_W'(MAX_DIM)
                 + PA_W'(ci_ff[DIX_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ci_ff <= '0;
         inv_ff <= 1'b0;
         stored_ff <= '0;
      end else if (cmd.take) begin
         if (req_last_coordinate) begin
            ci_ff <= '0;
            inv_ff <= 1'b0;
         end else begin
            ci_ff <= count_now;
            inv_ff <= inv_now;
         end
         if (key_we) begin
            stored_ff <= stored_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && in_range) begin
         qbuf_ff[ci_ff[DIX_W-1:0]] <= coord_v;
      end
   end

   // scan address generation
   logic [CNT_W-1:0]      slot_ff;
   logic [DIX_W-1:0]      dix_ff;
   logic [CI_W-1:0]       len_ff;
   logic                  dim_end;
   logic [COORD_BITS-1:0] pt_rdata;
   logic [15:0]           key_rdata;

   assign dim_end = (CI_W'(dix_ff) + CI_W'(1)) == len_ff;
   assign pt_raddr = PA_W'(slot_ff[SLOT_W-1:0]) * PA_W'(MAX_DIM) + PA_W'(dix_ff);

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         slot_ff <= '0;
         dix_ff <= '0;
         len_ff <= count_now;
      end else if (cmd.scan_issue) begin
         if (dim_end) begin
            dix_ff <= '0;
            slot_ff <= slot_ff + CNT_W'(1);
         end else begin
            dix_ff <= dix_ff + DIX_W'(1);
         end
      end
   end

   bfk_ram #(.WIDTH(COORD_BITS), .DEPTH(PDEPTH)) u_point_ram (
      .clock (clock),
      .we    (pt_we),
      .waddr (pt_waddr),
      .wdata (coord_v),
      .raddr (pt_raddr),
      .rdata (pt_rdata)
   );

   bfk_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (stored_ff[SLOT_W-1:0]),
      .wdata (req_entry_key),
      .raddr (slot_ff[SLOT_W-1:0]),
      .rdata (key_rdata)
   );

   // distance pipeline: read, difference, square, accumulate
   logic                  v1_ff, v2_ff, v3_ff, cand_v_ff;
   logic                  first1_ff, first2_ff, first3_ff;
   logic                  last1_ff, last2_ff, last3_ff;
   logic [COORD_BITS-1:0] q1_ff, diff2_ff;
   logic [15:0]           key2_ff, key3_ff, cand_key_ff;
   logic [SQ_W-1:0]       sq3_ff;
   logic [DIST_W-1:0]     acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         cand_v_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         cand_v_ff <= v3_ff && last3_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= (dix_ff == '0);
      last1_ff <= dim_end;
      q1_ff <= qbuf_ff[dix_ff];
      first2_ff <= first1_ff;
      last2_ff <= last1_ff;
      key2_ff <= key_rdata;
      diff2_ff <= (q1_ff > pt_rdata) ? q1_ff - pt_rdata : pt_rdata - q1_ff;
      first3_ff <= first2_ff;
      last3_ff <= last2_ff;
      key3_ff <= key2_ff;
      sq3_ff <= SQ_W'(diff2_ff) * SQ_W'(diff2_ff);
      cand_key_ff <= key3_ff;
      if (v3_ff) begin
         acc_ff <= first3_ff ? DIST_W'(sq3_ff) : acc_ff + DIST_W'(sq3_ff);
      end
   end

   // sorted best list, nearest first
   logic [DIST_W-1:0] bd_ff [MAX_K];
   logic [15:0]       bk_ff [MAX_K];
   logic [DIST_W-1:0] nd [MAX_K];
   logic [15:0]       nk [MAX_K];
   logic [MAX_K-1:0]  ahead, keep;
   logic [KC_W-1:0]   bcnt_ff, lim;
   logic              full, before_last, drop;

   always_comb begin
      lim = (KL_W'(k_ff) > KL_W'(MAX_K)) ? KC_W'(MAX_K) : KC_W'(k_ff);
      full = bcnt_ff == lim;
      before_last = 1'b0;
      for (int i = 0; i < MAX_K; i++) begin
         ahead[i] = (acc_ff < bd_ff[i]) ||
                    ((acc_ff == bd_ff[i]) && (cand_key_ff < bk_ff[i]));
         keep[i] = (KC_W'(i) < bcnt_ff) && !ahead[i];
         if (KC_W'(i) + KC_W'(1) == lim) before_last = ahead[i];
      end
      drop = (lim == '0) || (full && !before_last);
   end

   for (genvar g = 0; g < MAX_K; g++) begin : g_ins
      if (g == 0) begin : g_head
         always_comb begin
            nd[g] = keep[g] ? bd_ff[g] : acc_ff;
            nk[g] = keep[g] ? bk_ff[g] : cand_key_ff;
         end
      end else begin : g_body
         always_comb begin
            if (keep[g]) begin
               nd[g] = bd_ff[g];
               nk[g] = bk_ff[g];
            end else if (keep[g-1]) begin
               nd[g] = acc_ff;
               nk[g] = cand_key_ff;
            end else begin
               nd[g] = bd_ff[g-1];
               nk[g] = bk_ff[g-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cand_v_ff && !drop) begin
         for (int i = 0; i < MAX_K; i++) begin
            bd_ff[i] <= nd[i];
            bk_ff[i] <= nk[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= '0;
      end else if (cmd.scan_start) begin
         bcnt_ff <= '0;
      end else if (cand_v_ff && !drop && !full) begin
         bcnt_ff <= bcnt_ff + KC_W'(1);
      end
   end

   // emission, farthest first
   logic [KC_W-1:0]  ptr_ff, ptr_m1;
   logic [KIX_W-1:0] eix;
   logic             in_radius;

   always_comb begin
      ptr_m1 = ptr_ff - KC_W'(1);
      eix = KIX_W'(ptr_m1);
      in_radius = CMP_W'(bd_ff[eix]) < CMP_W'(r2_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_init) begin
         ptr_ff <= bcnt_ff;
      end else if (cmd.emit_step && ptr_ff != '0) begin
         ptr_ff <= ptr_m1;
      end
   end

   // output register
   logic        out_v_ff;
   logic [2:0]  out_st_ff;
   logic [15:0] out_key_ff;
   logic        out_last_ff;
   logic        rsp_free, ld;
   logic [2:0]  ld_st;
   logic [15:0] ld_key;
   logic        ld_last;

   assign rsp_free = !out_v_ff || rsp_ready;

   always_comb begin
      ld = 1'b0;
      ld_st = bfk_pkg::ST_QUERY_DONE;
      ld_key = '0;
      ld_last = 1'b1;
      if (close_take && !(req_kind && good)) begin
         ld = 1'b1;
         if (req_kind) ld_st = bfk_pkg::ST_QUERY_REJECT;
         else if (!good) ld_st = bfk_pkg::ST_BAD_POINT;
         else if (!room) ld_st = bfk_pkg::ST_STORE_FULL;
         else ld_st = bfk_pkg::ST_INSERTED;
      end else if (cmd.emit_step) begin
         if (ptr_ff == '0) begin
            ld = 1'b1;
         end else if (in_radius) begin
            ld = 1'b1;
            ld_st = bfk_pkg::ST_NEIGHBOR;
            ld_key = bk_ff[eix];
            ld_last = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (ld) begin
         out_v_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         out_st_ff <= ld_st;
         out_key_ff <= ld_key;
         out_last_ff <= ld_last;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_status = out_st_ff;
   assign rsp_neighbor_key = out_key_ff;
   assign rsp_last_result = out_last_ff;

   always_comb begin
      stat.rsp_free = rsp_free;
      stat.query_go = req_last_coordinate && req_kind && good;
      stat.issue_done = slot_ff == stored_ff;
      stat.pipe_busy = v1_ff || v2_ff || v3_ff || cand_v_ff;
      stat.emit_end = ptr_ff == '0;
   end
endmodule

// ----- bench/knn_scoreboard.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knn_scoreboard
// Watches the request, response and register channels of the search block,
// keeps its own copy of the point store and predicts every response item.
// ----------------------------------------------------------------------------
module knn_scoreboard (
   input  logic clock,
   input  logic reset,
   bfk_req_if   req_mon,
   bfk_rsp_if   rsp_mon,
   bfk_csr_if   csr_mon,
   output int   fail_count,
   output int   outstanding
);

   localparam int NPOINTS = 1024;
   localparam int NDIM = 16;
   localparam int NK = 16;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] key;
      logic        last;
   } knn_result_type;

   knn_result_type pending_results[$];

   logic [15:0] point_mem [0:NPOINTS-1][0:NDIM-1];
   logic [15:0] key_mem [0:NPOINTS-1];
   logic [15:0] query_coord [0:NDIM-1];
   int          points_held;
   int          coord_idx;
   bit          point_bad;
   logic [4:0]  dim_reg;
   logic [15:0] radius_reg;
   logic [4:0]  k_reg;

   logic [63:0] near_dist [0:NK-1];
   logic [15:0] near_key [0:NK-1];
   int          near_slot [0:NK-1];
   int          near_count;

   function automatic bit outranks(logic [63:0] d, logic [15:0] k, int s, int i);
      if (d != near_dist[i]) return d < near_dist[i];
      if (k != near_key[i]) return k < near_key[i];
      return s < near_slot[i];
   endfunction

   function automatic void keep_if_near(logic [63:0] d, logic [15:0] k, int s, int limit);
      int pos;
      if (limit == 0) return;
      if (near_count == limit) begin
         if (!outranks(d, k, s, limit - 1)) return;
         near_count--;
      end
      pos = near_count;
      while (pos > 0 && outranks(d, k, s, pos - 1)) begin
         near_dist[pos] = near_dist[pos-1];
         near_key[pos] = near_key[pos-1];
         near_slot[pos] = near_slot[pos-1];
         pos--;
      end
      near_dist[pos] = d;
      near_key[pos] = k;
      near_slot[pos] = s;
      near_count++;
   endfunction

   function automatic logic [63:0] squared_distance(int slot, int dim);
      logic [63:0] sum, a, b, diff, sq;
      sum = '0;
      for (int i = 0; i < dim; i++) begin
         a = {48'd0, query_coord[i]};
         b = {48'd0, point_mem[slot][i]};
         diff = (a > b) ? a - b : b - a;
         sq = diff * diff;
         if (sum > ~64'd0 - sq) sum = ~64'd0;
         else sum = sum + sq;
      end
      return sum;
   endfunction

   function automatic void add_result(logic [2:0] st, logic [15:0] key, logic last);
      knn_result_type r;
      r.status = st;
      r.key = key;
      r.last = last;
      pending_results = {pending_results, r};
   endfunction

   function automatic void predict_item(logic kind, logic [15:0] c, logic [15:0] key,
                                        logic last);
      int          count, limit;
      bit          good;
      logic [63:0] r2;
      if (coord_idx < NDIM) begin
         if (c[15]) point_bad = 1;
         query_coord[coord_idx] = c;
         if (points_held < NPOINTS) point_mem[points_held][coord_idx] = c;
         coord_idx++;
      end else begin
         point_bad = 1;
      end
      if (!last) return;
      count = coord_idx;
      good = !point_bad && count == dim_reg;
      coord_idx = 0;
      point_bad = 0;
      if (kind == 1'b0) begin
         if (!good) add_result(bfk_pkg::ST_BAD_POINT, '0, 1'b1);
         else if (points_held >= NPOINTS) add_result(bfk_pkg::ST_STORE_FULL, '0, 1'b1);
         else begin
            key_mem[points_held] = key;
            points_held++;
            add_result(bfk_pkg::ST_INSERTED, '0, 1'b1);
         end
         return;
      end
      if (!good) begin
         add_result(bfk_pkg::ST_QUERY_REJECT, '0, 1'b1);
         return;
      end
      limit = (k_reg > NK) ? NK : k_reg;
      r2 = {48'd0, radius_reg} * {48'd0, radius_reg};
      near_count = 0;
      for (int s = 0; s < points_held; s++)
         keep_if_near(squared_distance(s, count), key_mem[s], s, limit);
      for (int i = near_count - 1; i >= 0; i--)
         if (near_dist[i] < r2) add_result(bfk_pkg::ST_NEIGHBOR, near_key[i], 1'b0);
      add_result(bfk_pkg::ST_QUERY_DONE, '0, 1'b1);
   endfunction

   always @(posedge clock) begin
      knn_result_type want;
      if (reset) begin
         pending_results.delete();
         points_held = 0;
         coord_idx = 0;
         point_bad = 0;
         near_count = 0;
         dim_reg = bfk_pkg::DIMENSION_RESET;
         radius_reg = bfk_pkg::RADIUS_RESET;
         k_reg = bfk_pkg::K_RESET;
         fail_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               bfk_pkg::CSR_DIMENSION: dim_reg = csr_mon.data[4:0];
               bfk_pkg::CSR_RADIUS: radius_reg = csr_mon.data;
               bfk_pkg::CSR_K: k_reg = csr_mon.data[4:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count < 50)
                  $display("%0t: unexpected item status=%0d key=%h last=%b", $time,
                           rsp_mon.status, rsp_mon.neighbor_key, rsp_mon.last_result);
            end else begin
               want = pending_results.pop_front();
               if (rsp_mon.status !== want.status || rsp_mon.neighbor_key !== want.key ||
                   rsp_mon.last_result !== want.last) begin
                  fail_count++;
                  if (fail_count < 50)
                     $display("%0t: mismatch expected status=%0d key=%h last=%b,",
                              $time, want.status, want.key, want.last,
                              " got status=%0d key=%h last=%b", rsp_mon.status,
                              rsp_mon.neighbor_key, rsp_mon.last_result);
               end
            end
         end
         // request last: its results can never be on the response port this edge
         if (req_mon.valid && req_mon.ready)
            predict_item(req_mon.kind, req_mon.coordinate, req_mon.entry_key,
                         req_mon.last_coordinate);
      end
      outstanding = pending_results.size();
   end

endmodule

// ----- bench/brute_force_knn_search_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brute_force_knn_search_top_test
// Drives inserts, queries and register writes into the search block under
// varying back pressure; the scoreboard predicts and checks the responses.
// ----------------------------------------------------------------------------
module brute_force_knn_search_top_test;

   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_go;
   int   hold_left;
   int   idle_cycles;

   bfk_req_if req_ch ();
   bfk_rsp_if rsp_ch ();
   bfk_csr_if csr_ch ();

   brute_force_knn_search_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   knn_scoreboard u_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) rsp_ch.ready <= 1'b0;
      else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_coord(logic kind, logic [15:0] c, logic [15:0] key, logic last);
      // each cycle the sender idles with the current probability
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.coordinate <= c;
      req_ch.entry_key <= key;
      req_ch.last_coordinate <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // a whole point taken from vals, key on the closing item
   task automatic send_point(logic kind, logic [15:0] vals[], logic [15:0] key);
      for (int i = 0; i < vals.size(); i++)
         send_coord(kind, vals[i], (i == vals.size() - 1) ? key : 16'($urandom),
                    (i == vals.size() - 1) ? 1'b1 : 1'b0);
   endtask

   // sender pauses until every expected item has arrived and the block is idle
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_coord(bit allow_neg);
      int sel;
      sel = $urandom_range(99);
      if (allow_neg && sel < 5) return 16'h8000 | 16'($urandom);
      if (sel < 15) return 16'h7FFF;
      if (sel < 25) return 16'h0000;
      if (sel < 55) return 16'($urandom_range(0, 7));
      return 16'($urandom_range(0, 32767));
   endfunction

   function automatic logic [15:0] rand_key();
      return ($urandom_range(1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
   endfunction

   task automatic random_point(int dim);
      logic [15:0] vals[];
      logic        kind;
      int          n;
      n = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : dim;
      kind = ($urandom_range(99) < 65) ? 1'b0 : 1'b1;
      vals = new[n];
      foreach (vals[i]) vals[i] = rand_coord(1);
      // the closing item carries the key and the kind
      for (int i = 0; i < n; i++)
         send_coord((i == n - 1) ? kind : logic'($urandom_range(1)), vals[i],
                    (i == n - 1) ? rand_key() : 16'($urandom),
                    (i == n - 1) ? 1'b1 : 1'b0);
   endtask

   initial begin
      logic [15:0] v[];
      int          sent, dim;
      reset = 1'b1;
      hold_go = 0;
      hold_left = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      req_ch.valid <= 1'b0;
      req_ch.kind <= 1'b0;
      req_ch.coordinate <= '0;
      req_ch.entry_key <= '0;
      req_ch.last_coordinate <= 1'b0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= bfk_pkg::CSR_DIMENSION;
      csr_ch.data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ties, bad points, rejects, zero radius and zero k
      write_reg(bfk_pkg::CSR_DIMENSION, 16'd2);
      write_reg(bfk_pkg::CSR_K, 16'd16);
      write_reg(bfk_pkg::CSR_RADIUS, 16'hFFFF);
      v = {16'h0000, 16'h0000};      send_point(1'b0, v, 16'hFFFF);
      v = {16'h7FFF, 16'h7FFF};      send_point(1'b0, v, 16'h0000);
      v = {16'h0000, 16'h0000};      send_point(1'b0, v, 16'h1234);
      v = {16'h0000, 16'h0000};      send_point(1'b0, v, 16'h1234);
      v = {16'h0005, 16'hFFFF};      send_point(1'b0, v, 16'h0001);
      v = {16'h0007};                send_point(1'b0, v, 16'h0002);
      v = {16'h0001, 16'h0002, 16'h0003}; send_point(1'b0, v, 16'h0003);
      v = {16'h0000, 16'h0000};      send_point(1'b1, v, 16'h0000);
      v = {16'h8000, 16'h0000};      send_point(1'b1, v, 16'h0000);
      drain();
      write_reg(bfk_pkg::CSR_RADIUS, 16'd0);
      v = {16'h0001, 16'h0001};      send_point(1'b1, v, 16'h0000);
      drain();
      write_reg(bfk_pkg::CSR_RADIUS, 16'd100);
      write_reg(bfk_pkg::CSR_K, 16'd0);
      v = {16'h0001, 16'h0001};      send_point(1'b1, v, 16'h0000);
      drain();
      write_reg(bfk_pkg::CSR_DIMENSION, 16'd31);
      v = {16'h0001};                send_point(1'b1, v, 16'h0000);
      drain();

      // random phases under three back-pressure settings
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 88 : 0;
         recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 25 : 0;
         for (int ph = 0; ph < 2; ph++) begin
            dim = ($urandom_range(5) == 0) ? 16 : $urandom_range(1, 4);
            if (mode == 0 && ph == 0) dim = 0;
            write_reg(bfk_pkg::CSR_DIMENSION, 16'(dim));
            write_reg(bfk_pkg::CSR_K, 16'($urandom_range(0, 17)));
            write_reg(bfk_pkg::CSR_RADIUS,
                      ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
            sent = 0;
            while (sent < 10) begin
               random_point((dim == 0) ? 2 : dim);
               sent += (dim == 0) ? 2 : dim;
            end
            drain();
         end
      end

      // receiver holds off while inserts keep coming, then query
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_reg(bfk_pkg::CSR_DIMENSION, 16'd1);
      write_reg(bfk_pkg::CSR_K, 16'd31);
      write_reg(bfk_pkg::CSR_RADIUS, 16'hFFFF);
      hold_go = 1;
      v = new[1];
      for (int i = 0; i < 10; i++) begin
         v[0] = rand_coord(0);
         send_point(1'b0, v, rand_key());
      end
      v[0] = 16'hFFFF;  send_point(1'b0, v, 16'h0005);
      v[0] = 16'd3;     send_point(1'b1, v, 16'h0000);
      drain();
      write_reg(bfk_pkg::CSR_RADIUS, 16'd1);
      v[0] = 16'd3;     send_point(1'b1, v, 16'h0000);
      drain();

      if (fail_count == 0 && outstanding == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
